// ===== hw/rtl/coarse_occlusion_grid_macros.svh =====
// Assertion macros for the coarse occlusion grid.
`ifndef COARSE_OCCLUSION_GRID_MACROS_SVH
`define COARSE_OCCLUSION_GRID_MACROS_SVH

`ifndef SYNTH

// Check cons in the same cycle as ante.
`define COG_ASSERT_IMPL(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("coarse_occlusion_grid: assertion failed");

// Check cons in the cycle after ante.
`define COG_ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("coarse_occlusion_grid: assertion failed");

`else

`define COG_ASSERT_IMPL(label, clk_s, rst_s, ante, cons)

`define COG_ASSERT_NEXT(label, clk_s, rst_s, ante, cons)

`endif

`endif

// ===== hw/rtl/cog_pkg.sv =====
// Shared types, constants and helpers for the coarse occlusion grid.
`default_nettype none

package cog_pkg;

    localparam int DEF_MAX_GRID_COLS = 32;
    localparam int DEF_MAX_GRID_ROWS = 32;

    localparam int OPCODE_W = 2;
    localparam int COORD_W  = 12;
    localparam int CFG_W    = 11;
    localparam int TALLY_W  = 16;
    localparam int DATA_W   = 32;
    localparam int PADDR_W  = 4;
    localparam int REG_IDX_W = 2;

    // Divider: 12-bit dividends, 11-bit divisor.
    localparam int DIV_W     = 12;
    localparam int DIV_STEPS = 12;
    localparam int DIV_CNT_W = 4;
    localparam int DIV_OPS   = 6;
    localparam int DIV_SEL_W = 3;
    localparam int SIGN_W    = 14;

    localparam logic [CFG_W-1:0] RST_CANVAS_WIDTH  = 11'd200;
    localparam logic [CFG_W-1:0] RST_CANVAS_HEIGHT = 11'd200;
    localparam logic [CFG_W-1:0] RST_BLOCK_SIZE    = 11'd8;

    localparam logic [TALLY_W-1:0] TALLY_MAX = '1;

    localparam logic [OPCODE_W-1:0] OP_MARK  = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_QUERY = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd2;

    localparam logic [REG_IDX_W-1:0] REG_CANVAS_WIDTH  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_CANVAS_HEIGHT = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_BLOCK_SIZE    = 2'd2;

    // Divider operand slots.
    localparam logic [DIV_SEL_W-1:0] DSEL_COLS = 3'd0;
    localparam logic [DIV_SEL_W-1:0] DSEL_ROWS = 3'd1;
    localparam logic [DIV_SEL_W-1:0] DSEL_X0   = 3'd2;
    localparam logic [DIV_SEL_W-1:0] DSEL_X1   = 3'd3;
    localparam logic [DIV_SEL_W-1:0] DSEL_Y0   = 3'd4;
    localparam logic [DIV_SEL_W-1:0] DSEL_Y1   = 3'd5;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_SETUP,
        ST_BASE,
        ST_SCAN,
        ST_DONE
    } state_t;

    // Magnitude of a 13-bit signed value; fits 12 bits for the coordinate range.
    function automatic logic [DIV_W-1:0] mag13(input logic signed [DIV_W:0] v);
        logic signed [DIV_W:0] n;
        begin
            n = -v;
            mag13 = v[DIV_W] ? n[DIV_W-1:0] : v[DIV_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/cog_if.sv =====
// Valid/ready channel interfaces for the input and result words.
`default_nettype none

interface cog_in_if;
    logic                                 valid;
    logic                                 ready;
    logic        [cog_pkg::OPCODE_W-1:0]  opcode;
    logic signed [cog_pkg::COORD_W-1:0]   min_x;
    logic signed [cog_pkg::COORD_W-1:0]   min_y;
    logic signed [cog_pkg::COORD_W-1:0]   max_x;
    logic signed [cog_pkg::COORD_W-1:0]   max_y;

    modport source (output valid, opcode, min_x, min_y, max_x, max_y, input ready);
    modport sink   (input valid, opcode, min_x, min_y, max_x, max_y, output ready);
endinterface

interface cog_out_if;
    logic                          valid;
    logic                          ready;
    logic                          occluded;
    logic [cog_pkg::TALLY_W-1:0]   culled_count;

    modport source (output valid, occluded, culled_count, input ready);
    modport sink   (input valid, occluded, culled_count, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/cog_ram.sv =====
// Generic simple dual-port RAM with registered read.
`default_nettype none

module cog_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/coarse_occlusion_grid.sv =====
// Top level of the coarse occlusion grid: sequencer, shared divider, cell bitmap.
//
// Usage:
//   in_ch carries one command word: opcode (mark, query, clear) and a pixel
//   rectangle [min_x, max_x) x [min_y, max_y). out_ch returns at most one
//   word per command: occluded (query hit) and culled_count (tally after it).
//   The APB port sets canvas width, canvas height and block size; any write
//   to one of them empties the grid and the tally (a clearing pass follows).
// Timing:
//   One command at a time. Mark and query run four coordinate divisions and
//   two grid-size divisions on one shared restoring divider, then visit the
//   covered cells at one cell per cycle through the single bitmap; a query
//   stops at its first clear cell. The scan is skipped when no cell is
//   covered, and an empty rectangle skips the divisions too. Clear sweeps
//   the bitmap one cell per cycle.
// Reset and stalls:
//   After reset the bitmap is swept to zero before in_ch goes ready;
//   configuration writes are taken anyway. A result waits in the output
//   register while out_ch stalls, and the next command is accepted
//   meanwhile; it finishes once the register is free.
`default_nettype none
`include "coarse_occlusion_grid_macros.svh"

module coarse_occlusion_grid #(
    parameter int MAX_GRID_COLS = cog_pkg::DEF_MAX_GRID_COLS,
    parameter int MAX_GRID_ROWS = cog_pkg::DEF_MAX_GRID_ROWS
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    cog_in_if.sink                              in_ch,
    cog_out_if.source                           out_ch,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [cog_pkg::PADDR_W-1:0]    paddr,
    input  wire logic [cog_pkg::DATA_W-1:0]     pwdata,
    output logic      [cog_pkg::DATA_W-1:0]     prdata,
    output logic                                pready
);

    localparam int CELLS = MAX_GRID_COLS * MAX_GRID_ROWS;
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int CW    = (MAX_GRID_COLS > 1) ? $clog2(MAX_GRID_COLS) : 1;
    localparam int RW    = (MAX_GRID_ROWS > 1) ? $clog2(MAX_GRID_ROWS) : 1;
    localparam int NCW   = $clog2(MAX_GRID_COLS + 1);
    localparam int NRW   = $clog2(MAX_GRID_ROWS + 1);
    localparam int SW    = ((AW > NCW) ? AW : NCW) + 1;
    localparam int PW    = RW + NCW;
    localparam logic [AW-1:0] CLR_LAST = AW'(CELLS - 1);

    localparam int DW  = cog_pkg::DIV_W;
    localparam int SGW = cog_pkg::SIGN_W;
    localparam int CFW = cog_pkg::CFG_W;
    localparam int TW  = cog_pkg::TALLY_W;
    localparam logic [cog_pkg::DIV_CNT_W-1:0] DIV_STORE =
        cog_pkg::DIV_CNT_W'(cog_pkg::DIV_STEPS + 1);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [CFW-1:0] cw_reg;
    logic [CFW-1:0] ch_reg;
    logic [CFW-1:0] bs_reg;
    logic [CFW-1:0] bs_eff;
    logic [cog_pkg::REG_IDX_W-1:0] reg_idx;
    logic cfg_wr;
    logic cfg_hit;

    assign pready  = 1'b1;
    assign reg_idx = paddr[cog_pkg::PADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite;
    // A block size of zero divides as one.
    assign bs_eff  = (bs_reg == '0) ? CFW'(1) : bs_reg;

    always_comb
    begin
        cfg_hit = 1'b0;
        prdata  = '0;
        case (reg_idx)
            cog_pkg::REG_CANVAS_WIDTH:
            begin
                cfg_hit = cfg_wr;
                prdata  = cog_pkg::DATA_W'(cw_reg);
            end
            cog_pkg::REG_CANVAS_HEIGHT:
            begin
                cfg_hit = cfg_wr;
                prdata  = cog_pkg::DATA_W'(ch_reg);
            end
            cog_pkg::REG_BLOCK_SIZE:
            begin
                cfg_hit = cfg_wr;
                prdata  = cog_pkg::DATA_W'(bs_reg);
            end
            default:
            begin
                cfg_hit = 1'b0;
                prdata  = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cw_reg <= cog_pkg::RST_CANVAS_WIDTH;
            ch_reg <= cog_pkg::RST_CANVAS_HEIGHT;
            bs_reg <= cog_pkg::RST_BLOCK_SIZE;
        end
        else if (cfg_hit)
        begin
            case (reg_idx)
                cog_pkg::REG_CANVAS_WIDTH:  cw_reg <= pwdata[CFW-1:0];
                cog_pkg::REG_CANVAS_HEIGHT: ch_reg <= pwdata[CFW-1:0];
                cog_pkg::REG_BLOCK_SIZE:    bs_reg <= pwdata[CFW-1:0];
                default:                    bs_reg <= bs_reg;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    cog_pkg::state_t state_reg;
    cog_pkg::state_t state_next;

    logic [AW-1:0] clr_cnt_reg;
    logic          owed_reg;
    logic          hit_reg;
    logic          act_reg;
    logic          pend_reg;
    logic          out_valid_reg;
    logic          out_occ_reg;
    logic [TW-1:0] out_cnt_reg;
    logic [TW-1:0] tally_reg;
    logic [TW-1:0] tally_next;
    logic [TW-1:0] tally_inc;
    logic          clr_tally;

    // Item word
    logic [cog_pkg::OPCODE_W-1:0]       op_reg;
    logic signed [cog_pkg::COORD_W-1:0] x0_reg;
    logic signed [cog_pkg::COORD_W-1:0] y0_reg;
    logic signed [cog_pkg::COORD_W-1:0] x1_reg;
    logic signed [cog_pkg::COORD_W-1:0] y1_reg;
    logic signed [DW:0]                 x1m;
    logic signed [DW:0]                 y1m;

    logic in_acc;
    logic in_rect_ok;
    logic out_free;
    logic is_query;

    assign in_acc     = in_ch.valid && in_ch.ready;
    assign in_rect_ok = (in_ch.min_x < in_ch.max_x) && (in_ch.min_y < in_ch.max_y);
    assign out_free   = !out_valid_reg || out_ch.ready;
    assign is_query   = (op_reg == cog_pkg::OP_QUERY);
    assign x1m        = $signed({x1_reg[cog_pkg::COORD_W-1], x1_reg}) - $signed((DW+1)'(1));
    assign y1m        = $signed({y1_reg[cog_pkg::COORD_W-1], y1_reg}) - $signed((DW+1)'(1));

    // ------------------------------------------------------------------
    // Shared restoring divider: load, twelve steps, store
    // ------------------------------------------------------------------
    logic [CFW-1:0]                   div_rem_reg;
    logic [DW-1:0]                    div_quo_reg;
    logic [cog_pkg::DIV_CNT_W-1:0]    div_cnt_reg;
    logic [cog_pkg::DIV_SEL_W-1:0]    div_sel_reg;
    logic [DW-1:0]                    q_reg [cog_pkg::DIV_OPS];
    logic [DW-1:0]                    div_operand;
    logic [DW-1:0]                    rem_sh;
    logic [DW:0]                      rem_diff;
    logic                             rem_ge;

    always_comb
    begin
        case (div_sel_reg)
            cog_pkg::DSEL_COLS: div_operand = DW'(cw_reg) + DW'(bs_eff) - DW'(1);
            cog_pkg::DSEL_ROWS: div_operand = DW'(ch_reg) + DW'(bs_eff) - DW'(1);
            cog_pkg::DSEL_X0:   div_operand = cog_pkg::mag13({x0_reg[DW-1], x0_reg});
            cog_pkg::DSEL_X1:   div_operand = cog_pkg::mag13(x1m);
            cog_pkg::DSEL_Y0:   div_operand = cog_pkg::mag13({y0_reg[DW-1], y0_reg});
            cog_pkg::DSEL_Y1:   div_operand = cog_pkg::mag13(y1m);
            default:            div_operand = '0;
        endcase
    end

    assign rem_sh   = {div_rem_reg, div_quo_reg[DW-1]};
    assign rem_diff = {1'b0, rem_sh} - (DW+1)'(bs_eff);
    assign rem_ge   = !rem_diff[DW];

    // ------------------------------------------------------------------
    // Cell range setup from the quotients
    // ------------------------------------------------------------------
    logic [NCW-1:0] cols_sat;
    logic [NRW-1:0] rows_sat;
    logic [DW-1:0]  fc_w;
    logic [DW-1:0]  fr_w;
    logic signed [SGW-1:0] lc_raw;
    logic signed [SGW-1:0] lr_raw;
    logic signed [SGW-1:0] col_max;
    logic signed [SGW-1:0] row_max;
    logic signed [SGW-1:0] lc_cl;
    logic signed [SGW-1:0] lr_cl;
    logic cells_empty;

    assign cols_sat = (q_reg[cog_pkg::DSEL_COLS] > DW'(MAX_GRID_COLS)) ?
                      NCW'(MAX_GRID_COLS) : q_reg[cog_pkg::DSEL_COLS][NCW-1:0];
    assign rows_sat = (q_reg[cog_pkg::DSEL_ROWS] > DW'(MAX_GRID_ROWS)) ?
                      NRW'(MAX_GRID_ROWS) : q_reg[cog_pkg::DSEL_ROWS][NRW-1:0];

    // A negative left or top edge clamps to cell zero.
    assign fc_w = x0_reg[DW-1] ? '0 : q_reg[cog_pkg::DSEL_X0];
    assign fr_w = y0_reg[DW-1] ? '0 : q_reg[cog_pkg::DSEL_Y0];

    // Truncation toward zero: negate the magnitude quotient for a negative edge.
    assign lc_raw = x1m[DW] ? -$signed(SGW'(q_reg[cog_pkg::DSEL_X1]))
                            :  $signed(SGW'(q_reg[cog_pkg::DSEL_X1]));
    assign lr_raw = y1m[DW] ? -$signed(SGW'(q_reg[cog_pkg::DSEL_Y1]))
                            :  $signed(SGW'(q_reg[cog_pkg::DSEL_Y1]));
    assign col_max = $signed(SGW'(cols_sat)) - $signed(SGW'(1));
    assign row_max = $signed(SGW'(rows_sat)) - $signed(SGW'(1));
    assign lc_cl   = (lc_raw > col_max) ? col_max : lc_raw;
    assign lr_cl   = (lr_raw > row_max) ? row_max : lr_raw;
    assign cells_empty = (lc_cl < $signed(SGW'(fc_w))) || (lr_cl < $signed(SGW'(fr_w)));

    // ------------------------------------------------------------------
    // Cell walker
    // ------------------------------------------------------------------
    logic [NCW-1:0] cols_reg;
    logic [CW-1:0]  fc_reg;
    logic [CW-1:0]  lc_reg;
    logic [RW-1:0]  fr_reg;
    logic [RW-1:0]  lr_reg;
    logic [CW-1:0]  col_reg;
    logic [RW-1:0]  row_reg;
    logic [AW-1:0]  row_base_reg;
    logic [AW-1:0]  addr_reg;
    logic [PW-1:0]  base_prod;
    logic [SW-1:0]  base_addr;
    logic [SW-1:0]  next_base;
    logic [SW-1:0]  next_row_addr;
    logic [SW-1:0]  next_col_addr;
    logic           col_end;
    logic           row_end;
    logic           miss;
    logic           scan_end;

    logic           ram_we;
    logic [AW-1:0]  ram_waddr;
    logic           ram_wdata;
    logic           ram_rdata;

    assign base_prod     = PW'(fr_reg) * PW'(cols_reg);
    assign base_addr     = SW'(base_prod[AW-1:0]) + SW'(fc_reg);
    assign next_base     = SW'(row_base_reg) + SW'(cols_reg);
    assign next_row_addr = SW'(next_base[AW-1:0]) + SW'(fc_reg);
    assign next_col_addr = SW'(addr_reg) + SW'(1);
    assign col_end       = (col_reg == lc_reg);
    assign row_end       = (row_reg == lr_reg);
    // Stop a query at the first clear cell.
    assign miss          = pend_reg && !ram_rdata;
    assign scan_end      = !act_reg && !pend_reg;

    assign tally_inc = (hit_reg && (tally_reg != cog_pkg::TALLY_MAX)) ?
                       tally_reg + TW'(1) : tally_reg;
    assign clr_tally = cfg_hit || (in_acc && (in_ch.opcode == cog_pkg::OP_CLEAR));

    always_comb
    begin
        tally_next = tally_reg;
        if (clr_tally)
        begin
            tally_next = '0;
        end
        else if ((state_reg == cog_pkg::ST_DONE) && out_free)
        begin
            tally_next = tally_inc;
        end
    end

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cog_pkg::ST_CLEAR:
            begin
                if (clr_cnt_reg == CLR_LAST)
                begin
                    state_next = owed_reg ? cog_pkg::ST_DONE : cog_pkg::ST_IDLE;
                end
            end
            cog_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    case (in_ch.opcode)
                        cog_pkg::OP_CLEAR:
                            state_next = cog_pkg::ST_CLEAR;
                        cog_pkg::OP_MARK,
                        cog_pkg::OP_QUERY:
                            state_next = in_rect_ok ? cog_pkg::ST_DIV : cog_pkg::ST_DONE;
                        default:
                            state_next = cog_pkg::ST_DONE;
                    endcase
                end
            end
            cog_pkg::ST_DIV:
            begin
                if ((div_cnt_reg == DIV_STORE) && (div_sel_reg == cog_pkg::DSEL_Y1))
                begin
                    state_next = cog_pkg::ST_SETUP;
                end
            end
            cog_pkg::ST_SETUP:
            begin
                state_next = cells_empty ? cog_pkg::ST_DONE : cog_pkg::ST_BASE;
            end
            cog_pkg::ST_BASE:
            begin
                state_next = cog_pkg::ST_SCAN;
            end
            cog_pkg::ST_SCAN:
            begin
                if (miss || scan_end)
                begin
                    state_next = cog_pkg::ST_DONE;
                end
            end
            cog_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = cog_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cog_pkg::ST_IDLE;
            end
        endcase
        // A register write changes the grid layout: restart the clearing pass.
        if (cfg_hit)
        begin
            state_next = cog_pkg::ST_CLEAR;
        end
    end

    // ------------------------------------------------------------------
    // Outputs of the sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        in_ch.ready = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = addr_reg;
        ram_wdata   = 1'b0;
        case (state_reg)
            cog_pkg::ST_IDLE:
            begin
                in_ch.ready = 1'b1;
            end
            cog_pkg::ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
                ram_wdata = 1'b0;
            end
            cog_pkg::ST_SCAN:
            begin
                ram_we    = act_reg && (op_reg == cog_pkg::OP_MARK);
                ram_waddr = addr_reg;
                ram_wdata = 1'b1;
            end
            default:
            begin
                in_ch.ready = 1'b0;
                ram_we      = 1'b0;
            end
        endcase
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.occluded     = out_occ_reg;
    assign out_ch.culled_count = out_cnt_reg;

    cog_ram #(
        .WIDTH (1),
        .DEPTH (CELLS)
    ) u_cells (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cog_pkg::ST_CLEAR;
            clr_cnt_reg   <= '0;
            owed_reg      <= 1'b0;
            hit_reg       <= 1'b0;
            act_reg       <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            tally_reg     <= '0;
            div_cnt_reg   <= '0;
            div_sel_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            tally_reg <= tally_next;

            if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (state_reg == cog_pkg::ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end

            case (state_reg)
                cog_pkg::ST_IDLE:
                begin
                    if (in_acc)
                    begin
                        hit_reg     <= 1'b0;
                        owed_reg    <= (in_ch.opcode == cog_pkg::OP_CLEAR);
                        clr_cnt_reg <= '0;
                        div_cnt_reg <= '0;
                        div_sel_reg <= cog_pkg::DSEL_COLS;
                    end
                end
                cog_pkg::ST_DIV:
                begin
                    if (div_cnt_reg == DIV_STORE)
                    begin
                        div_cnt_reg <= '0;
                        div_sel_reg <= div_sel_reg + cog_pkg::DIV_SEL_W'(1);
                    end
                    else
                    begin
                        div_cnt_reg <= div_cnt_reg + cog_pkg::DIV_CNT_W'(1);
                    end
                end
                cog_pkg::ST_SETUP:
                begin
                    hit_reg <= is_query;
                end
                cog_pkg::ST_BASE:
                begin
                    act_reg  <= 1'b1;
                    pend_reg <= 1'b0;
                end
                cog_pkg::ST_SCAN:
                begin
                    pend_reg <= act_reg && is_query;
                    if (act_reg && col_end && row_end)
                    begin
                        act_reg <= 1'b0;
                    end
                    if (miss)
                    begin
                        act_reg <= 1'b0;
                        hit_reg <= 1'b0;
                    end
                    else if (scan_end)
                    begin
                        hit_reg <= is_query;
                    end
                end
                cog_pkg::ST_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        owed_reg      <= 1'b0;
                    end
                end
                default:
                begin
                    act_reg <= act_reg;
                end
            endcase

            if (cfg_hit)
            begin
                clr_cnt_reg <= '0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            op_reg <= in_ch.opcode;
            x0_reg <= in_ch.min_x;
            y0_reg <= in_ch.min_y;
            x1_reg <= in_ch.max_x;
            y1_reg <= in_ch.max_y;
        end

        if (state_reg == cog_pkg::ST_DIV)
        begin
            if (div_cnt_reg == '0)
            begin
                div_quo_reg <= div_operand;
                div_rem_reg <= '0;
            end
            else if (div_cnt_reg == DIV_STORE)
            begin
                q_reg[div_sel_reg] <= div_quo_reg;
            end
            else
            begin
                div_rem_reg <= rem_ge ? rem_diff[CFW-1:0] : rem_sh[CFW-1:0];
                div_quo_reg <= {div_quo_reg[DW-2:0], rem_ge};
            end
        end

        if (state_reg == cog_pkg::ST_SETUP)
        begin
            cols_reg <= cols_sat;
            fc_reg   <= fc_w[CW-1:0];
            lc_reg   <= lc_cl[CW-1:0];
            fr_reg   <= fr_w[RW-1:0];
            lr_reg   <= lr_cl[RW-1:0];
        end

        if (state_reg == cog_pkg::ST_BASE)
        begin
            row_reg      <= fr_reg;
            col_reg      <= fc_reg;
            row_base_reg <= base_prod[AW-1:0];
            addr_reg     <= base_addr[AW-1:0];
        end

        // Advance along the row, then wrap to the next row.
        if ((state_reg == cog_pkg::ST_SCAN) && act_reg && !(col_end && row_end))
        begin
            if (col_end)
            begin
                row_reg      <= row_reg + RW'(1);
                col_reg      <= fc_reg;
                row_base_reg <= next_base[AW-1:0];
                addr_reg     <= next_row_addr[AW-1:0];
            end
            else
            begin
                col_reg  <= col_reg + CW'(1);
                addr_reg <= next_col_addr[AW-1:0];
            end
        end

        if ((state_reg == cog_pkg::ST_DONE) && out_free)
        begin
            out_occ_reg <= hit_reg;
            out_cnt_reg <= tally_inc;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `COG_ASSERT_NEXT(a_tally_no_drop, clk, rst_n, !clr_tally, tally_reg >= $past(tally_reg))
    `COG_ASSERT_NEXT(a_cfg_starts_clear, clk, rst_n, cfg_hit, (state_reg == cog_pkg::ST_CLEAR) && (clr_cnt_reg == '0) && (tally_reg == '0))
    `COG_ASSERT_IMPL(a_scan_in_range, clk, rst_n, (state_reg == cog_pkg::ST_SCAN) && act_reg, (col_reg >= fc_reg) && (col_reg <= lc_reg) && (row_reg >= fr_reg) && (row_reg <= lr_reg))

endmodule

`default_nettype wire
